>>> design/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned CELL_BITS = 16;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] LINE_FEED = 8'd10;
  localparam logic [7:0] SPACE     = 8'd32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } result_t;

endpackage

>>> design/text_console_writer_core.sv
// Text console writer top level: input handshake, output register, sequencer and cell store.
// A new line on the last row scrolls the screen up; clear writes all COLUMNS*ROWS cells.
// One item at a time; the scroll sweep (one read and one write per copied cell) sets the
//   worst case.
// Reset (rst, synchronous) homes the cursor and runs a zero-fill pass over all
//   COLUMNS*ROWS cells with in_stall high throughout.
module text_console_writer_core #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  char_code,
  input  logic [7:0]  color,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr
);
  import tcw_pkg::*;

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned CELL_W     = $clog2(CELL_COUNT);

  item_t                item;
  result_t              res;
  logic                 idle;
  logic                 in_take;
  logic                 res_valid;
  logic                 res_take;
  logic                 ram_we;
  logic [CELL_W-1:0]    ram_waddr;
  logic [CELL_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [CELL_W-1:0]    ram_raddr;
  logic [CELL_BITS-1:0] ram_rdata;

  // Take a new item only when the sequencer sits idle.
  assign in_stall = !idle;
  assign in_take  = in_valid && !in_stall;

  assign item.operation  = operation;
  assign item.char_code  = char_code;
  assign item.color      = color;
  assign item.cell_index = cell_index;

  // Hand the result over once the output register is free or draining.
  assign res_take = res_valid && (!out_valid || !out_stall);

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELL_W  (CELL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .item      (item),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      cursor_col <= res.cursor_col;
      cursor_row <= res.cursor_row;
      cell_char  <= res.cell_char;
      cell_attr  <= res.cell_attr;
    end
  end

endmodule

>>> design/tcw_cell_ram.sv
// Screen cell store: one write port, one registered read port.
module tcw_cell_ram #(
  parameter int unsigned DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [ADDR_W-1:0]              waddr,
  input  logic [tcw_pkg::CELL_BITS-1:0]  wdata,
  input  logic                           re,
  input  logic [ADDR_W-1:0]              raddr,
  output logic [tcw_pkg::CELL_BITS-1:0]  rdata
);
  import tcw_pkg::*;

  logic [CELL_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/tcw_ctrl.sv
// Sequencer, cursor state and shared address adder of the text console writer.
module tcw_ctrl #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF,
  parameter int unsigned CELL_W  = $clog2(COLUMNS * ROWS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_take,
  input  tcw_pkg::item_t                item,
  output logic                          idle,
  output logic                          res_valid,
  output tcw_pkg::result_t              res,
  input  logic                          res_take,
  output logic                          ram_we,
  output logic [CELL_W-1:0]             ram_waddr,
  output logic [tcw_pkg::CELL_BITS-1:0] ram_wdata,
  output logic                          ram_re,
  output logic [CELL_W-1:0]             ram_raddr,
  input  logic [tcw_pkg::CELL_BITS-1:0] ram_rdata
);
  import tcw_pkg::*;

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam int unsigned ROW_W      = $clog2(ROWS);

  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELL_COUNT - 1);
  localparam logic [CELL_W-1:0] LAST_COPY = CELL_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [CELL_W-1:0] ROW_STEP  = CELL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_EXEC    = 4'd2;
  localparam logic [3:0] S_NEWLINE = 4'd3;
  localparam logic [3:0] S_SCR_RD  = 4'd4;
  localparam logic [3:0] S_SCR_WR  = 4'd5;
  localparam logic [3:0] S_FILL    = 4'd6;
  localparam logic [3:0] S_READ    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]           state;
  logic [CELL_W-1:0]    addr;
  logic [CELL_W-1:0]    base;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  logic [CELL_BITS-1:0] fill;
  item_t                job;
  logic [7:0]           rd_char;
  logic [7:0]           rd_attr;

  logic [CELL_W-1:0]    alu_a;
  logic [CELL_W-1:0]    alu_b;
  logic [CELL_W-1:0]    alu_sum;
  logic                 idx_ok;
  logic                 put_write;

  assign idx_ok    = 32'(job.cell_index) < CELL_COUNT;
  assign put_write = (job.operation == OP_PUT) && (job.char_code != LINE_FEED);

  // Shared adder: cursor position, row base step and sweep address.
  always_comb begin
    case (state)
      S_EXEC: begin
        alu_a = base;
        alu_b = CELL_W'(col);
      end
      S_NEWLINE: begin
        alu_a = base;
        alu_b = ROW_STEP;
      end
      S_SCR_RD: begin
        alu_a = addr;
        alu_b = ROW_STEP;
      end
      default: begin
        alu_a = addr;
        alu_b = CELL_W'(1);
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = fill;
    ram_re    = 1'b0;
    ram_raddr = alu_sum;
    case (state)
      S_INIT, S_FILL: begin
        ram_we = 1'b1;
      end
      S_EXEC: begin
        if (put_write) begin
          ram_we    = 1'b1;
          ram_waddr = alu_sum;
          ram_wdata = {job.color, job.char_code};
        end else if (job.operation == OP_READ && idx_ok) begin
          ram_re    = 1'b1;
          ram_raddr = CELL_W'(job.cell_index);
        end
      end
      S_SCR_RD: begin
        ram_re = 1'b1;
      end
      S_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      addr  <= '0;
      base  <= '0;
      col   <= '0;
      row   <= '0;
      fill  <= '0;
    end else begin
      case (state)
        S_INIT: begin
          addr <= alu_sum;
          if (addr == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            job     <= item;
            rd_char <= '0;
            rd_attr <= '0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (job.operation)
            OP_PUT: begin
              if (job.char_code == LINE_FEED || col == LAST_COL) begin
                state <= S_NEWLINE;
              end else begin
                col   <= col + 1'b1;
                state <= S_DONE;
              end
            end
            OP_CLEAR: begin
              fill  <= {job.color, SPACE};
              addr  <= '0;
              base  <= '0;
              col   <= '0;
              row   <= '0;
              state <= S_FILL;
            end
            OP_READ: begin
              state <= idx_ok ? S_READ : S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_NEWLINE: begin
          col <= '0;
          if (row == LAST_ROW) begin
            addr  <= '0;
            fill  <= {job.color, SPACE};
            state <= S_SCR_RD;
          end else begin
            row   <= row + 1'b1;
            base  <= alu_sum;
            state <= S_DONE;
          end
        end
        S_SCR_RD: begin
          state <= S_SCR_WR;
        end
        S_SCR_WR: begin
          addr  <= alu_sum;
          state <= (addr == LAST_COPY) ? S_FILL : S_SCR_RD;
        end
        S_FILL: begin
          addr <= alu_sum;
          if (addr == LAST_CELL) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          rd_char <= ram_rdata[7:0];
          rd_attr <= ram_rdata[15:8];
          state   <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle           = (state == S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.cursor_col = 7'(col);
  assign res.cursor_row = 5'(row);
  assign res.cell_char  = rd_char;
  assign res.cell_attr  = rd_attr;

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (rst) col <= LAST_COL)
    else $error("cursor column out of range");
  a_row_range: assert property (@(posedge clk) disable iff (rst) row <= LAST_ROW)
    else $error("cursor row out of range");
  a_base_track: assert property (@(posedge clk) disable iff (rst)
    base == CELL_W'(row * COLUMNS))
    else $error("row base out of step with cursor row");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    in_take |-> state == S_IDLE)
    else $error("item taken while busy");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> res_valid && $stable(res))
    else $error("pending result lost");
`endif

endmodule
